/* design/ftt_pkg.sv */
package ftt_pkg;

	// opcodes of an input beat
	localparam logic OP_REMEMBER = 1'b0;
	localparam logic OP_LOOKUP   = 1'b1;

	// protocol numbers with a timeout of their own
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TCP_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UDP_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_TIMEOUT = 2'd2;

	localparam int TMO_W  = 40;
	localparam int TIME_W = 48;
	localparam int SLOT_W = 6;

	// timeout reset values in microseconds
	localparam logic [TMO_W-1:0] TCP_TIMEOUT_RST   = 40'd900000000;
	localparam logic [TMO_W-1:0] UDP_TIMEOUT_RST   = 40'd120000000;
	localparam logic [TMO_W-1:0] OTHER_TIMEOUT_RST = 40'd30000000;

	// flow key and client address, one word of the entry memory
	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] peer;
		logic [31:0] target;
		logic [15:0] cli_port;
		logic [15:0] tgt_port;
		logic [63:0] client_hi;
		logic [63:0] client_lo;
	} entry_t;

	// valid flag and last-seen time, one word of the age memory
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] seen;
	} meta_t;

	// captured input beat
	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] now_time;
		entry_t            ent;
	} req_t;

	// result beat
	typedef struct packed {
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       client_hi;
		logic [63:0]       client_lo;
	} res_t;

endpackage

/* design/ftt_ram.sv */
module ftt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/ftt_cfg_regs.sv */
module ftt_cfg_regs
	import ftt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [TMO_W-1:0]     wr_data,
	input  logic [7:0]           proto,
	output logic [TMO_W-1:0]     tmo
);

	logic [TMO_W-1:0] tcp_tmo_q;
	logic [TMO_W-1:0] udp_tmo_q;
	logic [TMO_W-1:0] other_tmo_q;

	// timeout registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcp_tmo_q   <= TCP_TIMEOUT_RST;
			udp_tmo_q   <= UDP_TIMEOUT_RST;
			other_tmo_q <= OTHER_TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TCP_TIMEOUT:   tcp_tmo_q   <= wr_data;
				CFG_UDP_TIMEOUT:   udp_tmo_q   <= wr_data;
				CFG_OTHER_TIMEOUT: other_tmo_q <= wr_data;
				default: ;
			endcase
		end
	end

	// idle lifetime for the query's protocol
	always_comb begin
		if (proto == PROTO_TCP) begin
			tmo = tcp_tmo_q;
		end else if (proto == PROTO_UDP) begin
			tmo = udp_tmo_q;
		end else begin
			tmo = other_tmo_q;
		end
	end

endmodule

/* design/ftt_engine.sv */
module ftt_engine
	import ftt_pkg::*;
#(
	parameter int FLOW_ENTRIES = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  req_t             req,
	input  logic [TMO_W-1:0] tmo,
	output logic             busy,
	output res_t             res
);

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  addr_q;
	logic              issued_all_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              have_free_q;
	logic [IDX_W-1:0]  free_q;
	logic              have_old_q;
	logic [IDX_W-1:0]  old_q;
	logic [TIME_W-1:0] oldest_q;
	logic              matched_q;
	logic [IDX_W-1:0]  slot_q;
	res_t              res_q;

	entry_t            ent_rd;
	meta_t             meta_rd;
	logic              rd_en;
	logic              ent_we;
	logic              meta_we;
	logic [IDX_W-1:0]  meta_waddr;
	meta_t             meta_wdata;

	logic              is_last_s1;
	logic              live;
	logic              key_hit;
	logic              cli_hit;
	logic              rem_match;
	logic [TIME_W:0]   age;
	logic              expired;
	logic              lk_exp;
	logic              lk_match;
	logic              nxt_have_free;
	logic [IDX_W-1:0]  nxt_free;
	logic              nxt_have_old;
	logic [IDX_W-1:0]  nxt_old;
	logic [TIME_W-1:0] nxt_oldest;
	logic [IDX_W-1:0]  fin_slot;

	// key fields and client address
	ftt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (FLOW_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (slot_q),
		.wdata (req.ent),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (ent_rd)
	);

	// valid flag and last-seen time
	ftt_ram #(
		.WIDTH ($bits(meta_t)),
		.DEPTH (FLOW_ENTRIES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (meta_rd)
	);

	// compare the entry read back against the request
	always_comb begin
		is_last_s1 = (idx_s1 == LAST_IDX);
		live       = vld_s1 && meta_rd.valid;
		key_hit    = (ent_rd.proto == req.ent.proto) && (ent_rd.peer == req.ent.peer) &&
			(ent_rd.target == req.ent.target) &&
			(ent_rd.cli_port == req.ent.cli_port) &&
			(ent_rd.tgt_port == req.ent.tgt_port);
		cli_hit    = (ent_rd.client_hi == req.ent.client_hi) &&
			(ent_rd.client_lo == req.ent.client_lo);
		rem_match  = live && key_hit && cli_hit;
		age        = {1'b0, req.now_time} - {1'b0, meta_rd.seen};
		expired    = !age[TIME_W] && (age[TIME_W-1:0] > {{(TIME_W-TMO_W){1'b0}}, tmo});
		lk_exp     = live && expired;
		lk_match   = live && !expired && key_hit;
	end

	// free slot and oldest entry tracking for remember
	always_comb begin
		nxt_have_free = have_free_q;
		nxt_free      = free_q;
		nxt_have_old  = have_old_q;
		nxt_old       = old_q;
		nxt_oldest    = oldest_q;
		if (vld_s1 && !meta_rd.valid) begin
			nxt_have_free = 1'b1;
			nxt_free      = idx_s1;
		end
		if (live && !rem_match && (!have_old_q || meta_rd.seen < oldest_q)) begin
			nxt_have_old = 1'b1;
			nxt_old      = idx_s1;
			nxt_oldest   = meta_rd.seen;
		end
		fin_slot = nxt_have_free ? nxt_free : nxt_old;
	end

	// memory port control
	always_comb begin
		rd_en      = (state_q == ST_SCAN) && !issued_all_q;
		ent_we     = (state_q == ST_WRITE);
		meta_we    = 1'b0;
		meta_waddr = idx_s1;
		meta_wdata = '{valid: 1'b1, seen: req.now_time};
		unique case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = addr_q;
				meta_wdata = '0;
			end
			ST_SCAN: begin
				if (req.opcode == OP_LOOKUP) begin
					if (lk_exp) begin
						meta_we    = 1'b1;
						meta_wdata = '{valid: 1'b0, seen: meta_rd.seen};
					end else if (lk_match) begin
						meta_we = 1'b1;
					end
				end
			end
			ST_WRITE: begin
				meta_we    = 1'b1;
				meta_waddr = slot_q;
			end
			default: ;
		endcase
	end

	// sequencer, scan pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			have_free_q  <= 1'b0;
			free_q       <= '0;
			have_old_q   <= 1'b0;
			old_q        <= '0;
			oldest_q     <= '0;
			matched_q    <= 1'b0;
			slot_q       <= '0;
			res_q        <= '0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (go) begin
						state_q      <= ST_SCAN;
						addr_q       <= '0;
						issued_all_q <= 1'b0;
						vld_s1       <= 1'b0;
						have_free_q  <= 1'b0;
						have_old_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					// issue the next read
					vld_s1 <= rd_en;
					if (rd_en) begin
						idx_s1       <= addr_q;
						addr_q       <= addr_q + 1'b1;
						issued_all_q <= (addr_q == LAST_IDX);
					end
					// handle the entry read back
					if (vld_s1) begin
						if (req.opcode == OP_REMEMBER) begin
							have_free_q <= nxt_have_free;
							free_q      <= nxt_free;
							have_old_q  <= nxt_have_old;
							old_q       <= nxt_old;
							oldest_q    <= nxt_oldest;
							if (rem_match) begin
								matched_q <= 1'b1;
								slot_q    <= idx_s1;
								vld_s1    <= 1'b0;
								state_q   <= ST_WRITE;
							end else if (is_last_s1) begin
								matched_q <= 1'b0;
								slot_q    <= fin_slot;
								vld_s1    <= 1'b0;
								state_q   <= ST_WRITE;
							end
						end else begin
							if (lk_match) begin
								res_q.done      <= 1'b1;
								res_q.hit       <= 1'b1;
								res_q.slot      <= SLOT_W'(idx_s1);
								res_q.client_hi <= ent_rd.client_hi;
								res_q.client_lo <= ent_rd.client_lo;
								vld_s1          <= 1'b0;
								state_q         <= ST_IDLE;
							end else if (is_last_s1) begin
								res_q.done      <= 1'b1;
								res_q.hit       <= 1'b0;
								res_q.slot      <= '0;
								res_q.client_hi <= '0;
								res_q.client_lo <= '0;
								vld_s1          <= 1'b0;
								state_q         <= ST_IDLE;
							end
						end
					end
				end
				ST_WRITE: begin
					res_q.done      <= 1'b1;
					res_q.hit       <= matched_q;
					res_q.slot      <= SLOT_W'(slot_q);
					res_q.client_hi <= req.ent.client_hi;
					res_q.client_lo <= req.ent.client_lo;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign res  = res_q;

endmodule

/* design/flow_tracking_table.sv */
// channel   direction  handshake                  payload
// request   in         start, taken when !busy    opcode, now_time, proto_num, peer_addr,
//                                                 target_addr, client_port_in,
//                                                 target_port_in, client_hi_in, client_lo_in
// result    out        done, one cycle per beat   hit, slot_used, client_hi_out, client_lo_out
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one request at a time; the table is walked one entry per cycle through the single
// read port, and the walk stops at the first match or at the last entry; a remember
// also passes through a write state. busy drops in the cycle the result is shown.
// after reset the age memory is cleared one entry a cycle, with busy held high
// until every entry is cleared. config writes are taken in any cycle.
// the receiver cannot stall: done is high for exactly one cycle per result.
module flow_tracking_table
	import ftt_pkg::*;
#(
	parameter int FLOW_ENTRIES = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [TIME_W-1:0]    now_time,
	input  logic [7:0]           proto_num,
	input  logic [31:0]          peer_addr,
	input  logic [31:0]          target_addr,
	input  logic [15:0]          client_port_in,
	input  logic [15:0]          target_port_in,
	input  logic [63:0]          client_hi_in,
	input  logic [63:0]          client_lo_in,
	output logic                 done,
	output logic                 hit,
	output logic [SLOT_W-1:0]    slot_used,
	output logic [63:0]          client_hi_out,
	output logic [63:0]          client_lo_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0]     cfg_data
);

	logic             go;
	req_t             req_q;
	logic [TMO_W-1:0] tmo;
	res_t             res;

	assign go        = start && !busy;
	assign cfg_ready = 1'b1;

	// capture the request beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else if (go) begin
			req_q.opcode        <= opcode;
			req_q.now_time      <= now_time;
			req_q.ent.proto     <= proto_num;
			req_q.ent.peer      <= peer_addr;
			req_q.ent.target    <= target_addr;
			req_q.ent.cli_port  <= client_port_in;
			req_q.ent.tgt_port  <= target_port_in;
			req_q.ent.client_hi <= client_hi_in;
			req_q.ent.client_lo <= client_lo_in;
		end
	end

	// timeout registers
	ftt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.proto    (req_q.ent.proto),
		.tmo      (tmo)
	);

	// table walk and update
	ftt_engine #(
		.FLOW_ENTRIES (FLOW_ENTRIES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req_q),
		.tmo    (tmo),
		.busy   (busy),
		.res    (res)
	);

	assign done          = res.done;
	assign hit           = res.hit;
	assign slot_used     = res.slot;
	assign client_hi_out = res.client_hi;
	assign client_lo_out = res.client_lo;

	// a result only closes a request that was in progress
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result without a request in progress");

	// an accepted request holds the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after accepting a request");

	// a lookup miss reports slot zero and a zero client address
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit && req_q.opcode == OP_LOOKUP) |->
		(slot_used == '0 && client_hi_out == '0 && client_lo_out == '0))
		else $error("lookup miss with nonzero payload");

	// each request gives a single one-cycle result
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule
